/* design/wbd_pkg.sv */
// Package for the window beat detector: shared types and constants.
// No dependencies.
package wbd_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam logic [SAMPLE_W-1:0] RISE_LIMIT_RST = 8'd60;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL
  } wbd_state_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic second;
  } scan_ctrl_t;

endpackage

/* design/window_beat_detector.sv */
// Window beat detector top level: sequencer, window pointers and result register.
// Depends on wbd_pkg, wbd_ram and wbd_scan.
//
// Usage:
//   Input channel in_*: one 8-bit level sample per word. The sample is written
//   into a circular window memory of WINDOW_DEPTH entries, then the filled
//   entries are read back newest first, one per cycle, through the scan unit.
//   Result channel out_*: one word per sample, bit 0 the beat flag.
//   Configuration: cfg_wr_en with cfg_wr_data writes rise_limit (reset 60).
//   Flow: a new sample is taken only once the previous one is through; in_tready
//   is high only while the sequencer is idle.
//   Reset (rst_n low, synchronous): the window is empty, no result is pending.
//   Stall: a finished result holds in the output register; if the next one is
//   done before the receiver takes it, the sequencer waits and in_tready stays
//   low.
module window_beat_detector #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,    // [7:0] sample
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,   // [0] beat, [7:1] zero
  input  logic             cfg_wr_en,
  input  wbd_pkg::sample_t cfg_wr_data
);
  import wbd_pkg::*;

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);

  wbd_state_t state_r, state_nxt;

  logic [AW-1:0] head_r, head_nxt, rd_ptr_r;
  logic [CW-1:0] fill_r, issue_cnt_r, proc_cnt_r;
  logic          data_vld_r;
  sample_t       cur_r, rise_limit_r;
  logic          out_tvalid_r, out_beat_r;

  logic          in_acc, rd_en, out_load, scan_done;
  scan_ctrl_t    sctrl;
  sample_t       rd_data, lo, hi, best, prev;
  sample_t       mid, rise;
  logic          beat;

  assign in_acc    = in_tvalid && in_tready;
  assign head_nxt  = (head_r == LAST_ADDR) ? '0 : head_r + 1'b1;
  assign scan_done = data_vld_r && (proc_cnt_r == fill_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: rd_en     = (issue_cnt_r < fill_r);
      ST_EVAL: out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      fill_r       <= '0;
      data_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      rise_limit_r <= RISE_LIMIT_RST;
    end else begin
      state_r    <= state_nxt;
      data_vld_r <= rd_en;
      if (in_acc) begin
        head_r <= head_nxt;
        if (fill_r != FULL_CNT) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        rise_limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_ptr_r    <= head_nxt;
      issue_cnt_r <= '0;
      proc_cnt_r  <= '0;
      cur_r       <= in_tdata;
    end else begin
      if (rd_en) begin
        rd_ptr_r    <= (rd_ptr_r == '0) ? LAST_ADDR : rd_ptr_r - 1'b1;
        issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      if (data_vld_r) begin
        proc_cnt_r <= proc_cnt_r + 1'b1;
      end
    end
    if (out_load) begin
      out_beat_r <= beat;
    end
  end

  wbd_ram #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (head_nxt),
    .wdata (in_tdata),
    .re    (rd_en),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  assign sctrl.vld    = data_vld_r;
  assign sctrl.first  = (proc_cnt_r == '0);
  assign sctrl.second = (proc_cnt_r == CW'(1));

  wbd_scan u_scan (
    .clk  (clk),
    .ctrl (sctrl),
    .data (rd_data),
    .lo   (lo),
    .hi   (hi),
    .best (best),
    .prev (prev)
  );

  assign mid  = lo + ((hi - lo) >> 1);
  assign rise = (cur_r > prev) ? cur_r - prev : '0;
  assign beat = (cur_r > mid) && (prev < mid) && (rise > (best >> 1))
                && (rise > rise_limit_r);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_beat_r};

endmodule

/* design/wbd_ram.sv */
// Window sample memory: one write port and one registered read port.
// Depends on wbd_pkg.
module wbd_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  wbd_pkg::sample_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output wbd_pkg::sample_t rdata
);
  import wbd_pkg::*;

  sample_t mem [DEPTH];
  sample_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/wbd_scan.sv */
// Shared scan unit: min, max, largest older-minus-newer step and previous sample.
// Takes one window word per cycle, newest first. Depends on wbd_pkg.
module wbd_scan (
  input  logic              clk,
  input  wbd_pkg::scan_ctrl_t ctrl,
  input  wbd_pkg::sample_t  data,
  output wbd_pkg::sample_t  lo,
  output wbd_pkg::sample_t  hi,
  output wbd_pkg::sample_t  best,
  output wbd_pkg::sample_t  prev
);
  import wbd_pkg::*;

  sample_t lo_r, hi_r, best_r, prev_r, last_r;
  sample_t lo_nxt, hi_nxt, best_nxt, prev_nxt;
  sample_t step;

  always_comb begin
    step     = data - last_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    best_nxt = best_r;
    prev_nxt = prev_r;
    if (ctrl.first) begin
      lo_nxt   = data;
      hi_nxt   = data;
      best_nxt = '0;
      prev_nxt = '0;
    end else begin
      if (data < lo_r) begin
        lo_nxt = data;
      end
      if (data > hi_r) begin
        hi_nxt = data;
      end
      if (data > last_r && step > best_r) begin
        best_nxt = step;
      end
      if (ctrl.second) begin
        prev_nxt = data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.vld) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      best_r <= best_nxt;
      prev_r <= prev_nxt;
      last_r <= data;
    end
  end

  assign lo   = lo_r;
  assign hi   = hi_r;
  assign best = best_r;
  assign prev = prev_r;

endmodule

/* verif/testbench.sv */
// Self-checking bench for window_beat_detector: streams level samples, predicts each beat
// flag from a local window model and compares every result word in order.
// Depends on wbd_pkg and the design sources.
module testbench;
  import wbd_pkg::*;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 300000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [7:0] out_tdata;
  logic cfg_wr_en;
  sample_t cfg_wr_data;

  sample_t win [0:DEPTH-1];
  int unsigned fill;
  sample_t limit_q;
  bit beat_expected [$];

  int errors;
  int cycles;
  bit gaps_on;
  bit stalls_on;
  int hold_left;
  int stall_left;
  bit want_beat;

  window_beat_detector #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic bit shift_and_judge(sample_t s);
    int unsigned lo, hi, mid, best, rise, cur, prev;
    int i;
    if (fill < DEPTH) fill++;
    for (i = int'(fill) - 1; i >= 1; i--) win[i] = win[i-1];
    win[0] = s;
    cur = 32'(win[0]);
    prev = 32'(win[1]);
    lo = cur;
    hi = cur;
    for (i = 0; i < int'(fill); i++) begin
      if (win[i] < lo) lo = 32'(win[i]);
      if (win[i] > hi) hi = 32'(win[i]);
    end
    mid = lo + (hi - lo) / 2;
    best = 0;
    for (i = 0; i + 1 < int'(fill); i++) begin
      if (win[i+1] > win[i] && int'(win[i+1]) - int'(win[i]) > best)
        best = 32'(win[i+1]) - 32'(win[i]);
    end
    rise = (cur > prev) ? cur - prev : 0;
    return (cur > mid) && (prev < mid) && (rise > best / 2) && (rise > limit_q);
  endfunction

  task automatic report_mismatch(string what, int exp, int got);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, exp, got);
    errors++;
  endtask

  task automatic send_sample(sample_t s);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = s;
    do @(posedge clk); while (!in_tready);
    beat_expected.push_back(shift_and_judge(s));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (beat_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(sample_t v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    limit_q = v;
  endtask

  task automatic send_spike_run();
    int unsigned base, quiet, v, k;
    base = $urandom_range(0, 160);
    quiet = $urandom_range(2, 10);
    for (k = 0; k < quiet; k++) send_sample(sample_t'(base + $urandom_range(0, 6)));
    v = base + $urandom_range(20, 140);
    send_sample(sample_t'((v > 255) ? 255 : v));
    if ($urandom_range(0, 1) == 0) send_sample(sample_t'(base + $urandom_range(0, 40)));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (beat_expected.size() == 0) begin
        report_mismatch("unexpected word", 0, int'(out_tdata));
      end else begin
        want_beat = beat_expected.pop_front();
        if (out_tdata[0] !== want_beat)
          report_mismatch("beat", int'(want_beat), int'(out_tdata[0]));
        if (out_tdata[7:1] !== 7'd0) report_mismatch("pad bits", 0, int'(out_tdata[7:1]));
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic test_first_sample();
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd1);
    send_sample(8'd128);
    send_sample(8'd254);
    send_sample(8'h55);
    send_sample(8'haa);
    drain();
  endtask

  task automatic test_rise_limit();
    write_limit(8'd0);
    send_sample(8'd10);
    send_sample(8'd11);
    send_sample(8'd10);
    send_sample(8'd12);
    drain();
    write_limit(8'd255);
    send_sample(8'd0);
    send_sample(8'd255);
    drain();
    write_limit(8'd254);
    send_sample(8'd0);
    send_sample(8'd255);
    drain();
    write_limit(RISE_LIMIT_RST);
    send_sample(8'd100);
    send_sample(8'd160);
    send_sample(8'd100);
    send_sample(8'd161);
    drain();
  endtask

  task automatic test_full_window();
    int k;
    for (k = 0; k < 40; k++) send_sample(sample_t'(k * 2));
    send_sample(8'd0);
    send_sample(8'd200);
    drain();
  endtask

  task automatic test_backpressure();
    int k;
    hold_left = 400;
    for (k = 0; k < 10; k++) send_sample(sample_t'($urandom_range(0, 255)));
    drain();
  endtask

  task automatic test_random();
    int phase, k;
    for (phase = 0; phase < 6; phase++) begin
      write_limit(sample_t'($urandom_range(0, 120)));
      for (k = 0; k < 6; k++) send_spike_run();
      for (k = 0; k < 12; k++) begin
        if ($urandom_range(0, 2) == 0) send_sample(sample_t'($urandom_range(0, 255)));
        else send_sample(sample_t'($urandom_range(0, 40) + 100));
      end
      drain();
    end
  endtask

  task automatic test_no_idle();
    int k;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    write_limit(sample_t'($urandom_range(0, 80)));
    for (k = 0; k < 5; k++) send_spike_run();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    hold_left = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    fill = 0;
    limit_q = RISE_LIMIT_RST;
    for (int i = 0; i < DEPTH; i++) win[i] = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_first_sample();
    test_rise_limit();
    test_full_window();
    test_backpressure();
    test_random();
    test_no_idle();

    while (beat_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
